/* rtl/fen_pkg.sv */
// shared types and constants for the flow error norm block
package fen_pkg;

	localparam int DATA_W   = 32;
	localparam int FRAC_W   = 16;
	localparam int GUARD_W  = 20;
	localparam int ABS_W    = DATA_W + GUARD_W;
	localparam int SQ_W     = 64;
	localparam int NORM_W   = 48;
	localparam int GM1_W    = 20;
	localparam int STEP_W   = 6;
	localparam int NVAR     = 4;
	localparam logic [GM1_W-1:0] GM1_RESET = 20'd26214;
	localparam logic [STEP_W-1:0] DIV_STEPS = 6'd33;
	localparam logic [STEP_W-1:0] SQRT_STEPS = 6'd32;
	localparam logic [STEP_W-1:0] MUL_STEPS = 6'd17;
	localparam logic [STEP_W-1:0] SET1_STEP = 6'd6;
	localparam logic [STEP_W-1:0] SQ_STEP = 6'd12;

	typedef enum logic [1:0] {
		NK_L1   = 2'd0,
		NK_L2   = 2'd1,
		NK_LINF = 2'd2
	} norm_kind_t;

	typedef enum logic [3:0] {
		MOP_NONE,
		MOP_U,
		MOP_V,
		MOP_KX,
		MOP_KY,
		MOP_P,
		MOP_SQ0,
		MOP_SQ1,
		MOP_SQ2,
		MOP_SQ3
	} mul_op_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] test_density;
		logic signed [DATA_W-1:0] test_momentum_x;
		logic signed [DATA_W-1:0] test_momentum_y;
		logic signed [DATA_W-1:0] test_energy;
		logic signed [DATA_W-1:0] ref_density;
		logic signed [DATA_W-1:0] ref_momentum_x;
		logic signed [DATA_W-1:0] ref_momentum_y;
		logic signed [DATA_W-1:0] ref_energy;
		logic                     last_node;
	} node_t;

	typedef struct packed {
		norm_kind_t        norm_kind;
		logic [NORM_W-1:0] density_norm;
		logic [NORM_W-1:0] velocity_x_norm;
		logic [NORM_W-1:0] velocity_y_norm;
		logic [NORM_W-1:0] pressure_norm;
		logic              bad_density_seen;
		logic              last_norm;
	} norm_t;

	typedef struct packed {
		logic              load;
		logic              div_step;
		logic              div_done;
		mul_op_t           mop;
		logic              set;
		logic              sqrt_step;
		logic              emit;
		norm_kind_t        kind;
		logic [STEP_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic last_node;
		logic out_free;
	} sts_t;

endpackage

/* rtl/fen_ctrl.sv */
// sequencer for division, multiply steps, square roots and result output
module fen_ctrl import fen_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic node_valid,
	output logic busy,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_DIV  = 5'b00010,
		S_MUL  = 5'b00100,
		S_SQRT = 5'b01000,
		S_EMIT = 5'b10000
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] cnt_q;
	logic              set_q;
	logic              phase_q;
	norm_kind_t        kind_q;
	mul_op_t           mop;

	assign busy = (state_q != S_IDLE);

	// multiply schedule: per set u, v, u*mx, v*my, gap, p; then gap and four squares
	always_comb begin
		mop = MOP_NONE;
		if (cnt_q < SQ_STEP) begin
			unique case (cnt_q < SET1_STEP ? cnt_q : cnt_q - SET1_STEP)
				6'd0: mop = MOP_U;
				6'd1: mop = MOP_V;
				6'd2: mop = MOP_KX;
				6'd3: mop = MOP_KY;
				6'd5: mop = MOP_P;
				default: mop = MOP_NONE;
			endcase
		end else begin
			unique case (cnt_q)
				6'd13: mop = MOP_SQ0;
				6'd14: mop = MOP_SQ1;
				6'd15: mop = MOP_SQ2;
				6'd16: mop = MOP_SQ3;
				default: mop = MOP_NONE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.mop  = MOP_NONE;
		cmd.kind = kind_q;
		cmd.step = cnt_q;
		cmd.set  = set_q;
		unique case (state_q)
			S_IDLE: cmd.load = node_valid;
			S_DIV: begin
				cmd.div_step = (cnt_q < DIV_STEPS);
				cmd.div_done = (cnt_q == DIV_STEPS);
			end
			S_MUL: begin
				cmd.set = (cnt_q >= SET1_STEP);
				if (!phase_q) cmd.mop = mop;
			end
			S_SQRT: cmd.sqrt_step = 1'b1;
			S_EMIT: cmd.emit = 1'b1;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			set_q   <= 1'b0;
			phase_q <= 1'b0;
			kind_q  <= NK_L1;
		end else begin
			unique case (state_q)
				S_IDLE: if (node_valid) begin
					state_q <= S_DIV;
					cnt_q   <= '0;
					set_q   <= 1'b0;
				end
				S_DIV: begin
					if (cnt_q == DIV_STEPS) begin
						cnt_q <= '0;
						if (!set_q) begin
							set_q <= 1'b1;
						end else begin
							state_q <= S_MUL;
							phase_q <= 1'b0;
						end
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_MUL: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						if (cnt_q == MUL_STEPS - 6'd1) begin
							cnt_q <= '0;
							state_q <= sts.last_node ? S_SQRT : S_IDLE;
						end else begin
							cnt_q <= cnt_q + 6'd1;
						end
					end
				end
				S_SQRT: begin
					if (cnt_q == SQRT_STEPS - 6'd1) begin
						state_q <= S_EMIT;
						kind_q  <= NK_L1;
					end
					cnt_q <= cnt_q + 6'd1;
				end
				S_EMIT: if (sts.out_free) begin
					unique case (kind_q)
						NK_L1: kind_q <= NK_L2;
						NK_L2: kind_q <= NK_LINF;
						default: begin
							kind_q  <= NK_L1;
							state_q <= S_IDLE;
						end
					endcase
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/fen_dpath.sv */
// datapath: operand registers, divider, shared multiplier, accumulators, root lanes
module fen_dpath import fen_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  node_t             node,
	input  logic              cfg_valid,
	input  logic [GM1_W-1:0]  cfg_data,
	output logic              norm_valid,
	input  logic              norm_stall,
	output norm_t             norm
);

	localparam logic [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] NEG_MAG = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [ABS_W-1:0]  ABS_MAX = '1;

	node_t                     in_q;
	logic [GM1_W-1:0]          gm1_q;
	logic [DATA_W-1:0]         ovr_q [2];
	logic [DATA_W:0]           rem_q, quo_q;
	logic signed [DATA_W-1:0]  u_q [2];
	logic signed [DATA_W-1:0]  v_q [2];
	logic signed [DATA_W-1:0]  p_q [2];
	logic signed [DATA_W-1:0]  kx_q, ky_q, pre_q;
	logic [DATA_W-1:0]         d_q [NVAR];
	logic [ABS_W-1:0]          abs_q [NVAR];
	logic [SQ_W-1:0]           sq_q [NVAR];
	logic [DATA_W-1:0]         max_q [NVAR];
	logic                      bad_q;
	logic [SQ_W-1:0]           x_q [NVAR];
	logic [SQ_W-1:0]           r_q [NVAR];
	logic [2*DATA_W-1:0]       prod_s1;
	logic                      neg_s1, set_s1;
	mul_op_t                   mop_s1;
	logic                      out_free, out_load;

	function automatic logic [DATA_W-1:0] absdiff(input logic signed [DATA_W-1:0] a,
		input logic signed [DATA_W-1:0] b);
		logic signed [DATA_W:0] df;
		logic [DATA_W:0]        ng;
		df = {a[DATA_W-1], a} - {b[DATA_W-1], b};
		ng = -df;
		return df[DATA_W] ? ng[DATA_W-1:0] : df[DATA_W-1:0];
	endfunction

	// set selection
	logic signed [DATA_W-1:0] s_rho, s_mx, s_my, s_en;
	assign s_rho = cmd.set ? in_q.ref_density    : in_q.test_density;
	assign s_mx  = cmd.set ? in_q.ref_momentum_x : in_q.test_momentum_x;
	assign s_my  = cmd.set ? in_q.ref_momentum_y : in_q.test_momentum_y;
	assign s_en  = cmd.set ? in_q.ref_energy     : in_q.test_energy;

	always_ff @(posedge clk) begin
		if (cmd.load) in_q <= node;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) gm1_q <= GM1_RESET;
		else if (cfg_valid) gm1_q <= cfg_data;
	end

	// restoring divider for 2^(2*frac) / rho, one quotient bit a cycle
	logic [DATA_W:0] rem_b, quo_b, rem_sh, dvs;
	logic            ge;
	always_comb begin
		rem_b  = (cmd.step == '0) ? '0 : rem_q;
		quo_b  = (cmd.step == '0) ? '0 : quo_q;
		rem_sh = {rem_b[DATA_W-1:0], cmd.step == '0};
		dvs    = {1'b0, s_rho};
		ge     = (rem_sh >= dvs);
	end

	always_ff @(posedge clk) begin
		if (cmd.div_step) begin
			rem_q <= ge ? rem_sh - dvs : rem_sh;
			quo_q <= {quo_b[DATA_W-1:0], ge};
		end
		if (cmd.div_done) begin
			if (s_rho <= 0 || quo_q > {1'b0, POS_MAX}) ovr_q[cmd.set] <= POS_MAX;
			else ovr_q[cmd.set] <= quo_q[DATA_W-1:0];
		end
	end

	// shared multiplier, sign and magnitude
	logic signed [DATA_W:0] op_a, op_b;
	logic [DATA_W:0]        na, nb;
	logic [DATA_W-1:0]      ma, mb;
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (cmd.mop)
			MOP_U:   begin op_a = {1'b0, ovr_q[cmd.set]}; op_b = {s_mx[DATA_W-1], s_mx}; end
			MOP_V:   begin op_a = {1'b0, ovr_q[cmd.set]}; op_b = {s_my[DATA_W-1], s_my}; end
			MOP_KX:  begin
				op_a = {u_q[cmd.set][DATA_W-1], u_q[cmd.set]};
				op_b = {s_mx[DATA_W-1], s_mx};
			end
			MOP_KY:  begin
				op_a = {v_q[cmd.set][DATA_W-1], v_q[cmd.set]};
				op_b = {s_my[DATA_W-1], s_my};
			end
			MOP_P:   begin
				op_a = (DATA_W+1)'(gm1_q);
				op_b = {pre_q[DATA_W-1], pre_q};
			end
			MOP_SQ0: begin op_a = {1'b0, d_q[0]}; op_b = {1'b0, d_q[0]}; end
			MOP_SQ1: begin op_a = {1'b0, d_q[1]}; op_b = {1'b0, d_q[1]}; end
			MOP_SQ2: begin op_a = {1'b0, d_q[2]}; op_b = {1'b0, d_q[2]}; end
			MOP_SQ3: begin op_a = {1'b0, d_q[3]}; op_b = {1'b0, d_q[3]}; end
			default: begin op_a = '0; op_b = '0; end
		endcase
		na = -op_a;
		nb = -op_b;
		ma = op_a[DATA_W] ? na[DATA_W-1:0] : op_a[DATA_W-1:0];
		mb = op_b[DATA_W] ? nb[DATA_W-1:0] : op_b[DATA_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mop_s1 <= MOP_NONE;
		else mop_s1 <= cmd.mop;
	end

	always_ff @(posedge clk) begin
		prod_s1 <= (2*DATA_W)'(ma) * (2*DATA_W)'(mb);
		neg_s1  <= op_a[DATA_W] ^ op_b[DATA_W];
		set_s1  <= cmd.set;
	end

	// fixed-point product: drop fraction, saturate, restore sign
	logic [2*DATA_W-1:0]      shp;
	logic [DATA_W-1:0]        lim, qmag, qneg;
	logic signed [DATA_W-1:0] qres;
	always_comb begin
		shp  = prod_s1 >> FRAC_W;
		lim  = neg_s1 ? NEG_MAG : POS_MAX;
		qmag = (shp > (2*DATA_W)'(lim)) ? lim : shp[DATA_W-1:0];
		qneg = -qmag;
		qres = neg_s1 ? qneg : qmag;
	end

	always_ff @(posedge clk) begin
		unique case (mop_s1)
			MOP_U:  u_q[set_s1] <= qres;
			MOP_V:  v_q[set_s1] <= qres;
			MOP_KX: kx_q <= qres;
			MOP_KY: ky_q <= qres;
			MOP_P:  p_q[set_s1] <= qres;
			default: ;
		endcase
	end

	// energy less half the kinetic term, saturated
	logic signed [DATA_W:0]   ke, half;
	logic signed [DATA_W+1:0] ediff;
	always_comb begin
		ke    = {kx_q[DATA_W-1], kx_q} + {ky_q[DATA_W-1], ky_q};
		half  = (ke + $signed((DATA_W+1)'(ke[DATA_W]))) >>> 1;
		ediff = {{2{s_en[DATA_W-1]}}, s_en} - {half[DATA_W], half};
	end

	always_ff @(posedge clk) begin
		if (ediff[DATA_W+1:DATA_W-1] == 3'b000 || ediff[DATA_W+1:DATA_W-1] == 3'b111)
			pre_q <= ediff[DATA_W-1:0];
		else
			pre_q <= ediff[DATA_W+1] ? NEG_MAG : POS_MAX;
		d_q[0] <= absdiff(in_q.test_density, in_q.ref_density);
		d_q[1] <= absdiff(u_q[0], u_q[1]);
		d_q[2] <= absdiff(v_q[0], v_q[1]);
		d_q[3] <= absdiff(p_q[0], p_q[1]);
	end

	// accumulators
	logic       sq_we;
	logic [1:0] sq_k;
	always_comb begin
		sq_we = 1'b1;
		sq_k  = 2'd0;
		unique case (mop_s1)
			MOP_SQ0: sq_k = 2'd0;
			MOP_SQ1: sq_k = 2'd1;
			MOP_SQ2: sq_k = 2'd2;
			MOP_SQ3: sq_k = 2'd3;
			default: sq_we = 1'b0;
		endcase
	end

	logic [ABS_W:0] abs_nx;
	logic [SQ_W:0]  sq_nx;
	assign abs_nx = {1'b0, abs_q[sq_k]} + (ABS_W+1)'(d_q[sq_k]);
	assign sq_nx  = {1'b0, sq_q[sq_k]} + {1'b0, prod_s1};

	logic clr;
	assign clr = out_load && (cmd.kind == NK_LINF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NVAR; k++) begin
				abs_q[k] <= '0;
				sq_q[k]  <= '0;
				max_q[k] <= '0;
			end
			bad_q <= 1'b0;
		end else if (clr) begin
			for (int k = 0; k < NVAR; k++) begin
				abs_q[k] <= '0;
				sq_q[k]  <= '0;
				max_q[k] <= '0;
			end
			bad_q <= 1'b0;
		end else begin
			if (sq_we) begin
				abs_q[sq_k] <= (abs_nx > (ABS_W+1)'(ABS_MAX)) ? ABS_MAX : abs_nx[ABS_W-1:0];
				sq_q[sq_k]  <= sq_nx[SQ_W] ? '1 : sq_nx[SQ_W-1:0];
				if (d_q[sq_k] > max_q[sq_k]) max_q[sq_k] <= d_q[sq_k];
			end
			if (cmd.div_done && s_rho <= 0) bad_q <= 1'b1;
		end
	end

	// square root lanes, one result bit a cycle
	logic [5:0]      rsh;
	logic [SQ_W-1:0] rbit;
	assign rsh  = 6'd62 - {cmd.step[4:0], 1'b0};
	assign rbit = 64'd1 << rsh;

	always_ff @(posedge clk) begin
		if (cmd.sqrt_step) begin
			for (int k = 0; k < NVAR; k++) begin
				logic [SQ_W-1:0] xi, ri, tr;
				xi = (cmd.step == '0) ? sq_q[k] : x_q[k];
				ri = (cmd.step == '0) ? '0 : r_q[k];
				tr = ri + rbit;
				if (xi >= tr) begin
					x_q[k] <= xi - tr;
					r_q[k] <= (ri >> 1) + rbit;
				end else begin
					x_q[k] <= xi;
					r_q[k] <= ri >> 1;
				end
			end
		end
	end

	// output register
	logic [NORM_W-1:0] nv [NVAR];
	always_comb begin
		for (int k = 0; k < NVAR; k++) begin
			unique case (cmd.kind)
				NK_L1:   nv[k] = (abs_q[k][ABS_W-1:NORM_W] != '0) ? '1 : abs_q[k][NORM_W-1:0];
				NK_L2:   nv[k] = NORM_W'(r_q[k][DATA_W-1:0]);
				default: nv[k] = NORM_W'(max_q[k]);
			endcase
		end
	end

	assign out_free = !norm_valid || !norm_stall;
	assign out_load = cmd.emit && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) norm_valid <= 1'b0;
		else if (out_load) norm_valid <= 1'b1;
		else if (!norm_stall) norm_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			norm.norm_kind        <= cmd.kind;
			norm.density_norm     <= nv[0];
			norm.velocity_x_norm  <= nv[1];
			norm.velocity_y_norm  <= nv[2];
			norm.pressure_norm    <= nv[3];
			norm.bad_density_seen <= bad_q;
			norm.last_norm        <= (cmd.kind == NK_LINF);
		end
	end

	assign sts.last_node = in_q.last_node;
	assign sts.out_free  = out_free;

endmodule

/* rtl/flow_error_norms.sv */
// top level of the flow error norm block
// Takes one grid node a request on the node channel (test and reference density, momenta
// and energy in signed Q16.16) and accumulates L1, sum of squares and maximum of the
// absolute differences of density, x velocity, y velocity and pressure. A node is held
// through the accept state, two 33-step restoring divisions for the reciprocal densities
// (one shared divider, each with a finishing step), then 17 slots of the one shared
// 32x32 multiplier. On a node flagged last_node four square-root lanes then run in
// parallel, after which three requests leave on the norm channel (L1, root of L2,
// L-infinity) as fast as the sink takes them; the accumulators and the bad density flag
// clear with the third. The user writes gamma minus one through the cfg channel only
// while idle, which the block itself does not enforce; it resets to about 0.4.
module flow_error_norms import fen_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             node_valid,
	output logic             node_stall,
	input  node_t            node,
	output logic             norm_valid,
	input  logic             norm_stall,
	output norm_t            norm,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [GM1_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;
	logic busy;

	// new node only while the sequencer is idle
	assign node_stall = busy;
	// register write always taken
	assign cfg_ready  = 1'b1;

	fen_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.node_valid (node_valid),
		.busy       (busy),
		.sts        (sts),
		.cmd        (cmd)
	);

	fen_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.node       (node),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.norm_valid (norm_valid),
		.norm_stall (norm_stall),
		.norm       (norm)
	);

	// an accepted node keeps the block busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(node_valid && !node_stall) |=> node_stall)
		else $error("block not busy after node accept");

	// results only appear while a sample is being closed
	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(norm_valid) |-> $past(node_stall))
		else $error("result raised outside sample close");

	// last flag goes with the maximum
	a_last_is_linf: assert property (@(posedge clk) disable iff (!arst_n)
		(norm_valid && norm.last_norm) |-> (norm.norm_kind == NK_LINF))
		else $error("last result is not the maximum");

endmodule

/* tb/sv/testbench.sv */
// self-checking testbench for the flow error norm block
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import fen_pkg::*;

	localparam longint unsigned HALF = 64'h8000_0000;
	localparam longint signed SMAX = 64'sh7FFF_FFFF;
	localparam longint unsigned ABS_MAX = (64'd1 << ABS_W) - 1;
	localparam longint unsigned OUT_MAX = 64'hFFFF_FFFF_FFFF;
	// a node holds the block through divisions and multiplies, a sample end adds the root pass
	localparam int SETTLE_CYCLES = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic node_valid = 1'b0;
	logic node_stall;
	node_t node = '0;
	logic norm_valid;
	logic norm_stall = 1'b0;
	norm_t norm;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [GM1_W-1:0] cfg_data = '0;

	flow_error_norms u_dut (
		.clk(clk), .arst_n(arst_n),
		.node_valid(node_valid), .node_stall(node_stall), .node(node),
		.norm_valid(norm_valid), .norm_stall(norm_stall), .norm(norm),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// model state: gamma minus one and the per-variable accumulators
	logic [GM1_W-1:0] gm1_model;
	longint unsigned l1_acc[NVAR];
	longint unsigned sq_acc[NVAR];
	longint unsigned max_acc[NVAR];
	bit bad_rho_model;

	node_t pending_nodes[$];
	norm_t expected_norms[$];
	int mismatches = 0;
	bit long_hold = 1'b0;
	int node_gap = 0;
	int norm_gap = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic longint signed clamp32(longint signed x);
		if (x > SMAX) return SMAX;
		if (x < -longint'(HALF)) return -longint'(HALF);
		return x;
	endfunction

	// q16 product with magnitude truncation and saturation to 32 bits
	function automatic longint signed fx_mul(longint signed a, longint signed b);
		bit neg;
		logic [127:0] prod;
		logic [127:0] shifted;
		longint unsigned lim;
		longint unsigned ma;
		longint unsigned mb;
		neg = (a < 0) != (b < 0);
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		prod = 128'(ma) * 128'(mb);
		shifted = prod >> FRAC_W;
		lim = neg ? HALF : HALF - 1;
		if (shifted > 128'(lim)) shifted = 128'(lim);
		return neg ? -longint'(shifted[63:0]) : longint'(shifted[63:0]);
	endfunction

	task automatic primitives(input logic signed [31:0] rho, input logic signed [31:0] mx,
			input logic signed [31:0] my, input logic signed [31:0] en,
			output longint signed u, output longint signed v, output longint signed p);
		longint signed recip;
		longint signed ke;
		longint unsigned q;
		if (rho <= 0) begin
			recip = SMAX;
			bad_rho_model = 1'b1;
		end else begin
			q = (64'd1 << (2 * FRAC_W)) / longint'(rho);
			recip = q > HALF - 1 ? SMAX : longint'(q);
		end
		u = fx_mul(recip, mx);
		v = fx_mul(recip, my);
		ke = fx_mul(u, mx) + fx_mul(v, my);
		p = fx_mul(longint'(gm1_model), clamp32(longint'(en) - ke / 2));
	endtask

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned add_sat(longint unsigned a, longint unsigned b,
			longint unsigned lim);
		if (a > lim || b > lim - a) return lim;
		return a + b;
	endfunction

	// accumulate one node and queue the three norms when it closes a sample
	task automatic predict_norms(input node_t n);
		longint signed t[4];
		longint signed r[4];
		longint unsigned d;
		longint unsigned sq;
		longint unsigned val;
		norm_t o;
		t[0] = n.test_density;
		r[0] = n.ref_density;
		primitives(n.test_density, n.test_momentum_x, n.test_momentum_y, n.test_energy,
			t[1], t[2], t[3]);
		primitives(n.ref_density, n.ref_momentum_x, n.ref_momentum_y, n.ref_energy,
			r[1], r[2], r[3]);
		for (int k = 0; k < NVAR; k++) begin
			d = t[k] >= r[k] ? t[k] - r[k] : r[k] - t[k];
			sq = d > 64'hFFFF_FFFF ? 64'hFFFF_FFFF_FFFF_FFFF : d * d;
			l1_acc[k] = add_sat(l1_acc[k], d, ABS_MAX);
			sq_acc[k] = add_sat(sq_acc[k], sq, 64'hFFFF_FFFF_FFFF_FFFF);
			if (d > max_acc[k]) max_acc[k] = d;
		end
		if (!n.last_node) return;
		for (int kind = 0; kind < 3; kind++) begin
			o = '0;
			o.norm_kind = norm_kind_t'(kind);
			for (int k = 0; k < NVAR; k++) begin
				if (kind == NK_L1) val = l1_acc[k];
				else if (kind == NK_L2) val = int_sqrt(sq_acc[k]);
				else val = max_acc[k];
				if (val > OUT_MAX) val = OUT_MAX;
				case (k)
					0: o.density_norm = val[NORM_W-1:0];
					1: o.velocity_x_norm = val[NORM_W-1:0];
					2: o.velocity_y_norm = val[NORM_W-1:0];
					default: o.pressure_norm = val[NORM_W-1:0];
				endcase
			end
			o.bad_density_seen = bad_rho_model;
			o.last_norm = kind == NK_LINF;
			expected_norms.push_back(o);
		end
		for (int k = 0; k < NVAR; k++) begin
			l1_acc[k] = 0;
			sq_acc[k] = 0;
			max_acc[k] = 0;
		end
		bad_rho_model = 1'b0;
	endtask

	// gap lengths: mostly none or short, now and then long
	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(99);
		if (sel < 50) return 0;
		if (sel < 92) return $urandom_range(3, 1);
		return $urandom_range(60, 10);
	endfunction

	// node driver: presents the queue head and pops it when accepted
	always @(posedge clk) begin
		if (node_valid && !node_stall) begin
			void'(pending_nodes.pop_front());
			node_gap <= pick_gap();
			if (pending_nodes.size() > 0 && pick_gap() == 0) begin
				node <= pending_nodes[0];
			end else begin
				node_valid <= 1'b0;
			end
		end else if (!node_valid && arst_n) begin
			if (node_gap > 0) begin
				node_gap <= node_gap - 1;
			end else if (pending_nodes.size() > 0) begin
				node_valid <= 1'b1;
				node <= pending_nodes[0];
			end
		end
	end

	// model runs on the accepted request
	always @(posedge clk) begin
		if (arst_n && node_valid && !node_stall) predict_norms(node);
	end

	// sink back-pressure, with the long hold forced by the stimulus process
	always @(posedge clk) begin
		if (long_hold) begin
			norm_stall <= 1'b1;
		end else if (norm_gap > 0) begin
			norm_gap <= norm_gap - 1;
			norm_stall <= 1'b1;
		end else begin
			norm_stall <= 1'b0;
			if ($urandom_range(3) == 0) norm_gap <= pick_gap();
		end
	end

	// monitor: compare each norm request with the oldest prediction
	always @(posedge clk) begin
		norm_t exp_n;
		if (arst_n && norm_valid && !norm_stall) begin
			if (expected_norms.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected norm request %p", norm);
			end else begin
				exp_n = expected_norms.pop_front();
				if (norm !== exp_n) begin
					mismatches++;
					if (mismatches <= 10)
						$display("norm mismatch: expected %p actual %p", exp_n, norm);
				end
			end
		end
	end

	function automatic logic [31:0] rand_word();
		case ($urandom_range(7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3: return 32'(int'($urandom_range(65536 * 4)) - 65536 * 2);
			default: return $urandom();
		endcase
	endfunction

	// well-formed node: positive densities of order one, moderate momenta and energy
	function automatic node_t physical_node(bit last);
		node_t n;
		n.test_density = 32'($urandom_range(65536 * 3, 16384));
		n.ref_density = ($urandom_range(3) == 0) ? n.test_density
			: 32'($urandom_range(65536 * 3, 16384));
		n.test_momentum_x = 32'(int'($urandom_range(65536 * 4)) - 65536 * 2);
		n.test_momentum_y = 32'(int'($urandom_range(65536 * 4)) - 65536 * 2);
		n.test_energy = 32'($urandom_range(65536 * 20));
		n.ref_momentum_x = n.test_momentum_x + 32'(int'($urandom_range(2000)) - 1000);
		n.ref_momentum_y = n.test_momentum_y + 32'(int'($urandom_range(2000)) - 1000);
		n.ref_energy = n.test_energy + 32'($urandom_range(5000));
		n.last_node = last;
		return n;
	endfunction

	function automatic node_t noise_node(bit last);
		node_t n;
		n.test_density = rand_word();
		n.test_momentum_x = rand_word();
		n.test_momentum_y = rand_word();
		n.test_energy = rand_word();
		n.ref_density = rand_word();
		n.ref_momentum_x = rand_word();
		n.ref_momentum_y = rand_word();
		n.ref_energy = rand_word();
		n.last_node = last;
		return n;
	endfunction

	task automatic wait_idle();
		while (pending_nodes.size() > 0 || node_valid || expected_norms.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_gm1(input logic [GM1_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		gm1_model = val;
	endtask

	initial begin
		node_t n;
		logic [GM1_W-1:0] gm1_phase[4];
		gm1_phase = '{20'hFFFFF, 20'd0, 20'd26214, 20'd45875};
		gm1_model = GM1_RESET;
		for (int k = 0; k < NVAR; k++) begin
			l1_acc[k] = 0;
			sq_acc[k] = 0;
			max_acc[k] = 0;
		end
		bad_rho_model = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset gamma, field extremes, bad densities, single-node samples
		pending_nodes.push_back(physical_node(1'b1));
		n = '0;
		n.last_node = 1'b1;
		pending_nodes.push_back(n);
		n = '1;
		pending_nodes.push_back(n);
		n = '{default: 32'h7FFF_FFFF, last_node: 1'b0};
		pending_nodes.push_back(n);
		n = '{default: 32'h8000_0000, last_node: 1'b1};
		pending_nodes.push_back(n);
		n = physical_node(1'b0);
		n.test_density = 32'h0;
		pending_nodes.push_back(n);
		n = physical_node(1'b1);
		n.ref_density = -32'sd65536;
		pending_nodes.push_back(n);
		// tiny density makes the reciprocal saturate, huge momenta saturate products
		n = physical_node(1'b0);
		n.test_density = 32'd1;
		n.test_momentum_x = 32'h7FFF_FFFF;
		n.ref_momentum_y = 32'h8000_0000;
		pending_nodes.push_back(n);
		n = physical_node(1'b1);
		n.test_energy = 32'h8000_0000;
		n.ref_energy = 32'h7FFF_FFFF;
		pending_nodes.push_back(n);
		// saturating sums over a run of extreme nodes
		for (int i = 0; i < 6; i++) begin
			n = '{default: 32'h7FFF_FFFF, last_node: 1'b0};
			n.ref_density = 32'h8000_0000;
			n.ref_momentum_x = 32'h8000_0000;
			n.last_node = i == 5;
			pending_nodes.push_back(n);
		end
		for (int i = 0; i < 6; i++) pending_nodes.push_back(noise_node(i % 2));
		wait_idle();

		// random phases across several gamma settings, the extremes among them
		for (int ph = 0; ph < 4; ph++) begin
			write_gm1(gm1_phase[ph]);
			if (ph == 1) begin
				// sink holds off long while nodes keep arriving
				long_hold = 1'b1;
				for (int i = 0; i < 10; i++) pending_nodes.push_back(physical_node(1'b1));
				repeat (1500) @(posedge clk);
				long_hold = 1'b0;
			end
			for (int i = 0; i < 90; i++) begin
				if ($urandom_range(9) < 8)
					pending_nodes.push_back(physical_node($urandom_range(4) == 0));
				else
					pending_nodes.push_back(noise_node($urandom_range(4) == 0));
			end
			n = physical_node(1'b1);
			pending_nodes.push_back(n);
			wait_idle();
		end
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// watchdog: ~400 nodes plus stalls and holds, taken well over
	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

/* flow_error_norms.f */
rtl/fen_pkg.sv
rtl/fen_ctrl.sv
rtl/fen_dpath.sv
rtl/flow_error_norms.sv
tb/sv/testbench.sv
